@@ rtl/mcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpd_pkg
// Shared types and constants of the multichannel PCM deframer: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mcpd_pkg;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned LEN_W        = 32;
   localparam int unsigned CHAN_W       = 5;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned RSP_DATA_W   = 16;
   localparam logic [CHAN_W-1:0] LIMIT_RESET = 5'd20;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_CHECK,
      ST_DIVIDE,
      ST_ERROR,
      ST_PAYLOAD,
      ST_SKIP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic hdr_load;   // take a header beat
      logic run_load;   // arm frame counters from the header
      logic div_start;  // start the block length division
      logic blk_load;   // take the quotient as block length
      logic pay_step;   // take a payload beat and emit its result
      logic skip_step;  // take a skipped beat
      logic err_emit;   // emit the error result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hdr_last;    // next header beat is the eighth
      logic count_bad;   // count zero or above a limit
      logic div_done;    // division finished this cycle
      logic rem_nonzero; // count does not divide length
      logic len_zero;    // payload length is zero
      logic last_byte;   // beat in progress is the last of the payload
      logic out_free;    // result register can take a result
   } status_type;

endpackage

@@ rtl/mcpd_div.sv @@
// ----------------------------------------------------------------------------
// mcpd_div
// Restoring divider, one quotient bit per cycle, for the payload length
// divided by the channel count.
// ----------------------------------------------------------------------------
module mcpd_div #(
   parameter int unsigned DIV_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mcpd_pkg::LEN_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic                      done,
   output logic [mcpd_pkg::LEN_W-1:0] quotient,
   output logic                      rem_nonzero
);
   import mcpd_pkg::*;

   localparam int unsigned CNT_W = $clog2(LEN_W);

   logic [LEN_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[LEN_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(LEN_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[LEN_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

@@ rtl/mcpd_dpath.sv @@
// ----------------------------------------------------------------------------
// mcpd_dpath
// Datapath: header assembly, limit checks, divider, frame counters, the
// channel limit register and the result register.
// ----------------------------------------------------------------------------
module mcpd_dpath #(
   parameter int unsigned CHANNEL_CAP = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcpd_pkg::cmd_type              cmd,
   output mcpd_pkg::status_type           status,
   input  logic [mcpd_pkg::BYTE_W-1:0]    in_byte,
   input  logic                           csr_write,
   input  logic [mcpd_pkg::CHAN_W-1:0]    csr_value,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [mcpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import mcpd_pkg::*;

   localparam int unsigned DIV_W = $clog2(CHANNEL_CAP + 1);
   localparam int unsigned HB_W  = $clog2(HEADER_BYTES);

   logic [CHAN_W-1:0] limit_ff;
   logic [HB_W-1:0]   hdr_cnt_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  count_ff;
   logic [LEN_W-1:0]  remain_ff;
   logic [LEN_W-1:0]  block_len_ff;
   logic [LEN_W-1:0]  block_left_ff;
   logic [CHAN_W-1:0] chan_ff;

   logic              out_valid_ff;
   logic [CHAN_W-1:0] out_chan_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_bend_ff;
   logic              out_fend_ff;
   logic              out_err_ff;

   logic              div_done;
   logic              div_rem_nz;
   logic [LEN_W-1:0]  div_quo;
   logic              bend;
   logic              fend;

   mcpd_div #(.DIV_W(DIV_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend    (len_ff),
      .divisor     (count_ff[DIV_W-1:0]),
      .done        (div_done),
      .quotient    (div_quo),
      .rem_nonzero (div_rem_nz)
   );

   assign bend = block_left_ff == LEN_W'(1);
   assign fend = remain_ff <= LEN_W'(1);

   always_comb begin
      status.hdr_last    = hdr_cnt_ff == HB_W'(HEADER_BYTES - 1);
      status.count_bad   = (count_ff == '0)
                         || (count_ff > {{(LEN_W-CHAN_W){1'b0}}, limit_ff})
                         || (count_ff > LEN_W'(CHANNEL_CAP));
      status.div_done    = div_done;
      status.rem_nonzero = div_rem_nz;
      status.len_zero    = len_ff == '0;
      status.last_byte   = fend;
      status.out_free    = !out_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_value;
      end
   end

   // Header words arrive least significant byte first, so shifting in from
   // the top leaves them in place after four beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= '0;
      end else if (cmd.hdr_load) begin
         hdr_cnt_ff <= hdr_cnt_ff + 1'b1;
      end
      if (cmd.hdr_load) begin
         if (!hdr_cnt_ff[HB_W-1]) begin
            len_ff <= {in_byte, len_ff[LEN_W-1:BYTE_W]};
         end else begin
            count_ff <= {in_byte, count_ff[LEN_W-1:BYTE_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run_load) begin
         remain_ff <= len_ff;
         chan_ff   <= '0;
      end else if (cmd.pay_step || cmd.skip_step) begin
         remain_ff <= remain_ff - 1'b1;
         if (cmd.pay_step && bend) begin
            chan_ff <= chan_ff + 1'b1;
         end
      end
      if (cmd.blk_load) begin
         block_len_ff  <= div_quo;
         block_left_ff <= div_quo;
      end else if (cmd.pay_step) begin
         block_left_ff <= bend ? block_len_ff : block_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.pay_step || cmd.err_emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.pay_step) begin
         out_chan_ff <= chan_ff;
         out_byte_ff <= in_byte;
         out_bend_ff <= bend;
         out_fend_ff <= fend;
         out_err_ff  <= 1'b0;
      end else if (cmd.err_emit) begin
         out_chan_ff <= '0;
         out_byte_ff <= '0;
         out_bend_ff <= 1'b0;
         out_fend_ff <= 1'b0;
         out_err_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CHAN_W-BYTE_W-1){1'b0}},
                        out_bend_ff, out_byte_ff, out_chan_ff};
   assign rsp_tlast  = out_fend_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

@@ rtl/mcpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcpd_ctrl
// Controller: walks header, check, division, error, payload and skip
// phases and issues datapath commands.
// ----------------------------------------------------------------------------
module mcpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mcpd_pkg::status_type status,
   output mcpd_pkg::cmd_type    cmd
);
   import mcpd_pkg::*;

   state_type state_ff, state_in;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

   assign take = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_HEADER: begin
            req_tready   = status.out_free;
            cmd.hdr_load = req_tvalid && req_tready;
            if (req_tvalid && req_tready && status.hdr_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.run_load = 1'b1;
            if (status.count_bad) begin
               state_in = ST_ERROR;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.rem_nonzero) begin
                  state_in = ST_ERROR;
               end else begin
                  cmd.blk_load = 1'b1;
                  state_in     = status.len_zero ? ST_HEADER : ST_PAYLOAD;
               end
            end
         end
         ST_ERROR: begin
            if (status.out_free) begin
               cmd.err_emit = 1'b1;
               state_in     = status.len_zero ? ST_HEADER : ST_SKIP;
            end
         end
         ST_PAYLOAD: begin
            req_tready   = status.out_free;
            cmd.pay_step = req_tvalid && req_tready;
            if (req_tvalid && req_tready && status.last_byte) begin
               state_in = ST_HEADER;
            end
         end
         ST_SKIP: begin
            req_tready    = 1'b1;
            cmd.skip_step = req_tvalid && req_tready;
            if (req_tvalid && req_tready && status.last_byte) begin
               state_in = ST_HEADER;
            end
         end
         default: begin
            state_in = ST_HEADER;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_DIVIDE || state_ff == ST_ERROR)
         |-> !req_tready)
      else $error("input beat offered ready during header evaluation");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_header_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEADER && take && status.hdr_last) |=> state_ff == ST_CHECK)
      else $error("eighth header beat did not lead to the check phase");

   a_result_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.pay_step || cmd.err_emit) |-> status.out_free)
      else $error("result issued while the result register was full");
`endif

endmodule

@@ rtl/multichannel_pcm_deframer.sv @@
// ----------------------------------------------------------------------------
// multichannel_pcm_deframer
// Deframes length-prefixed multichannel PCM frames into tagged payload beats.
// ----------------------------------------------------------------------------
// Header and payload beats are taken one per cycle while the result register
// can take a result; skipped payload of a rejected frame is taken one per cycle.
// After the eighth header beat the block stops taking beats for the limit
// checks, then the one-bit-per-cycle divider that derives the block length
// from the payload length and channel count, which is loaded as it finishes
// (a header that fails the limit checks goes straight to its error result).
// The result register takes a new payload beat in the same cycle that the
// previous result leaves, so a result held by the sink stalls the input.
module multichannel_pcm_deframer #(
   parameter int unsigned CHANNEL_CAP = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] channel_index, [12:5] sample_byte,
                                    // [13] block_end, [15:14] zero
   output logic        rsp_tlast,   // frame_end
   output logic        rsp_tuser,   // [0] frame_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // channel_limit
);
   import mcpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mcpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mcpd_dpath #(.CHANNEL_CAP(CHANNEL_CAP)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_byte    (req_tdata),
      .csr_write  (csr_valid),
      .csr_value  (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel PCM deframer. A byte-level model
// of the header parser tracks every accepted input beat and queues the
// tagged payload beats and error beats the block must produce. Directed
// frames cover the header corners and limit settings, then a long random
// stream of mostly well-formed frames runs under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import mcpd_pkg::*;

   localparam int unsigned CHAN_CAP    = 31;
   localparam int          SETTLE_CYC  = 48;
   localparam int          RANDOM_BEATS = 1700;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [BYTE_W-1:0] smp;
      logic              blk_end;
      logic              frm_end;
      logic              err;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CHAN_W-1:0]     csr_data = '0;

   // Parser model state.
   phase_type             phase;
   logic [2:0]            hdr_pos;
   logic [LEN_W-1:0]      frame_len;
   logic [LEN_W-1:0]      frame_chans;
   logic [LEN_W-1:0]      blk_len;
   logic [LEN_W-1:0]      pos_in_blk;
   logic [CHAN_W-1:0]     chan_q;
   logic [LEN_W-1:0]      left;
   logic [CHAN_W-1:0]     channel_limit_q;

   sample_type            pending_samples[$];
   int                    fail_count = 0;
   int                    sent_beats = 0;
   bit                    tx_steady = 1'b0;
   bit                    rx_steady = 1'b0;
   int                    rx_hold = 0;

   multichannel_pcm_deframer #(
      .CHANNEL_CAP(CHAN_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic void clear_parser();
      phase           = PH_HEADER;
      hdr_pos         = '0;
      frame_len       = '0;
      frame_chans     = '0;
      blk_len         = '0;
      pos_in_blk      = '0;
      chan_q          = '0;
      left            = '0;
      channel_limit_q = LIMIT_RESET;
      pending_samples.delete();
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      logic [2:0] pos;
      logic       bad;
      logic       bend;
      logic       fend;
      sample_type res;
      pos = hdr_pos;
      res = '0;
      case (phase)
         PH_HEADER: begin
            if (pos < 4) begin
               if (pos == 0) frame_len = '0;
               frame_len[8*pos[1:0] +: 8] = b;
            end else begin
               if (pos == 4) frame_chans = '0;
               frame_chans[8*pos[1:0] +: 8] = b;
            end
            if (pos != HEADER_BYTES - 1) begin
               hdr_pos = pos + 3'd1;
            end else begin
               hdr_pos = '0;
               if (frame_chans == 0) bad = 1'b1;
               else if (frame_chans > channel_limit_q) bad = 1'b1;
               else if (frame_chans > CHAN_CAP) bad = 1'b1;
               else bad = (frame_len % frame_chans) != 0;
               pos_in_blk = '0;
               chan_q     = '0;
               left       = frame_len;
               if (bad) begin
                  blk_len = '0;
                  phase   = (frame_len != 0) ? PH_SKIP : PH_HEADER;
                  res.err = 1'b1;
                  pending_samples.push_back(res);
               end else begin
                  blk_len = frame_len / frame_chans;
                  phase   = (frame_len != 0) ? PH_PAYLOAD : PH_HEADER;
               end
            end
         end
         PH_PAYLOAD: begin
            bend = ({1'b0, pos_in_blk} + 33'd1) >= {1'b0, blk_len};
            fend = left <= 1;
            res.chan    = chan_q;
            res.smp     = b;
            res.blk_end = bend;
            res.frm_end = fend;
            pending_samples.push_back(res);
            if (bend) begin
               pos_in_blk = '0;
               chan_q     = chan_q + 1'b1;
            end else begin
               pos_in_blk = pos_in_blk + 1;
            end
            if (fend) begin
               left       = '0;
               pos_in_blk = '0;
               chan_q     = '0;
               phase      = PH_HEADER;
            end else begin
               left = left - 1;
            end
         end
         default: begin
            if (left <= 1) begin
               left  = '0;
               phase = PH_HEADER;
            end else begin
               left = left - 1;
            end
         end
      endcase
   endfunction

   function automatic void cmp_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_sample();
      sample_type want;
      if (pending_samples.size() == 0) begin
         $error("result beat with no expectation waiting: tdata %h", rsp_tdata);
         fail_count++;
         return;
      end
      want = pending_samples.pop_front();
      cmp_field("channel_index", want.chan, rsp_tdata[4:0]);
      cmp_field("sample_byte", want.smp, rsp_tdata[12:5]);
      cmp_field("block_end", want.blk_end, rsp_tdata[13]);
      cmp_field("tdata padding", 0, rsp_tdata[15:14]);
      cmp_field("frame_end", want.frm_end, rsp_tlast);
      cmp_field("frame_error", want.err, rsp_tuser);
   endfunction

   // All handshakes are observed in one process, on values from before the edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
      end else begin
         if (csr_valid && csr_ready) channel_limit_q = csr_data;
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_sample();
      end
   end

   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else if (rsp_tready && !rx_steady) begin
         rsp_tready <= 1'b0;
         rx_hold    <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         rx_hold    <= $urandom_range(0, 6);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent_beats++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] cnt,
                             input bit patterned);
      logic [BYTE_W-1:0] pat [4];
      pat = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(cnt[8*i +: 8]);
      for (int i = 0; i < len; i++) send_byte(patterned ? pat[i % 4] : 8'($urandom));
   endtask

   // The block may still be dividing after the last result, so
   // let it settle before touching the register or ending the run. The first
   // edge lets the monitor record the last beat before the queue is looked at.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CHAN_W-1:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_frames();
      send_frame(3, 1, 1);
      send_frame(20, 20, 0);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      send_frame(12, 4, 1);
      send_frame(0, 2, 0);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      send_frame(6, 3, 1);
   endtask

   task automatic test_bad_headers();
      send_frame(4, 0, 0);
      send_frame(0, 0, 0);
      send_frame(2, 21, 1);
      send_frame(0, 32'hFFFF_FFFF, 0);
      send_frame(5, 32'h8000_0001, 1);
      send_frame(4, 3, 0);
      send_frame(4, 2, 1);
   endtask

   task automatic test_limit_settings();
      write_limit(5'd31);
      send_frame(31, 31, 0);
      send_frame(62, 31, 1);
      send_frame(32, 32, 0);
      write_limit(5'd0);
      send_frame(1, 1, 0);
      send_frame(0, 1, 0);
      write_limit(5'd1);
      send_frame(3, 1, 1);
      send_frame(2, 2, 0);
   endtask

   task automatic test_random_stream();
      int          base;
      int          kind;
      int          blk;
      int          lim_max;
      logic [4:0]  choice [5];
      logic [LEN_W-1:0] cnt;
      logic [LEN_W-1:0] len;
      base = sent_beats;
      while (sent_beats - base < RANDOM_BEATS) begin
         if ($urandom_range(0, 39) == 0) begin
            choice = '{5'd0, 5'd1, 5'd31, LIMIT_RESET, 5'($urandom)};
            write_limit(choice[$urandom_range(0, 4)]);
         end
         tx_steady = ($urandom_range(0, 4) == 0);
         rx_steady = ($urandom_range(0, 4) == 0);
         lim_max = (channel_limit_q == 0) ? 1 : channel_limit_q;
         blk = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            cnt = $urandom_range(1, lim_max);
            len = cnt * blk;
         end else if (kind < 80) begin
            cnt = '0;
            len = $urandom_range(0, 20);
         end else if (kind < 88) begin
            if (channel_limit_q < CHAN_CAP && $urandom_range(0, 1) == 0) begin
               cnt = $urandom_range(channel_limit_q + 1, CHAN_CAP);
            end else begin
               cnt = $urandom;
               if (cnt <= CHAN_CAP) cnt = cnt + 32;
            end
            len = $urandom_range(0, 40);
         end else if (kind < 96) begin
            cnt = $urandom_range(2, (lim_max < 2) ? 2 : lim_max);
            len = cnt * blk + $urandom_range(1, cnt - 1);
         end else begin
            cnt = $urandom_range(1, lim_max);
            len = '0;
         end
         send_frame(len, cnt, 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_basic_frames();
      test_bad_headers();
      test_limit_settings();
      test_random_stream();
      wait_idle();
      if (pending_samples.size() != 0) begin
         $error("%0d expected results never arrived", pending_samples.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mcpd_pkg.sv
rtl/mcpd_div.sv
rtl/mcpd_dpath.sv
rtl/mcpd_ctrl.sv
rtl/multichannel_pcm_deframer.sv
verif/tb.sv
